// ===== hdl/ecf_pkg.sv =====
// ----------------------------------------------------------------------------
// ecf_pkg
// Shared types and codes for the earliest-completion-first send/wait unit.
// ----------------------------------------------------------------------------
package ecf_pkg;

    // path_case codes (code 3 is unused and handled like no path)
    localparam logic [1:0] PATH_NONE   = 2'd0;
    localparam logic [1:0] PATH_SAME   = 2'd1;
    localparam logic [1:0] PATH_DIFF   = 2'd2;
    localparam logic [1:0] PATH_UNUSED = 2'd3;

    // configuration register map
    localparam int unsigned PADDR_W  = 3;
    localparam logic        REG_BETA = 1'b0;
    localparam logic [7:0]  BETA_RESET = 8'd4;

    typedef enum logic [1:0] {
        DEC_NONE      = 2'd0,
        DEC_SEND_FAST = 2'd1,
        DEC_SEND_SLOW = 2'd2,
        DEC_WAIT      = 2'd3
    } decision_t;

    typedef struct packed {
        logic [1:0]  path_case;
        logic [15:0] seg_size;
        logic [31:0] meta_queued_bytes;
        logic [31:0] sub_queued_bytes;
        logic [31:0] meta_packets_out;
        logic [31:0] sub_inflight_pkts;
        logic [15:0] fast_window;
        logic [31:0] fast_rtt;
        logic [31:0] fast_rtt_var;
        logic [15:0] slow_window;
        logic [31:0] slow_rtt;
        logic [31:0] slow_rtt_var;
    } item_t;

    typedef struct packed {
        logic [1:0] decision;
        logic       margin_after;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_BACK,
        ST_SEL,
        ST_PROD,
        ST_WGT,
        ST_DEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic direct;
        logic mul_en;
        logic back_en;
        logic sel_en;
        logic prod_en;
        logic wgt_en;
        logic dec_en;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
        logic need_calc;
    } status_t;

endpackage

// ===== hdl/ecf_subflow_send_or_wait_unit.sv =====
// ----------------------------------------------------------------------------
// ecf_subflow_send_or_wait_unit
// Earliest-completion-first choice between the chosen and the fastest path.
// ----------------------------------------------------------------------------
//
//   channel   signals                                    kind
//   -------   ----------------------------------------   -------------------
//   item      item_valid, item_ready, item (item_t)      input, valid/ready
//   result    result_valid, result_ready, result         output, valid/ready
//   apb       psel, penable, pwrite, paddr, pwdata,      config, beta at 0x0
//             prdata, pready
//
// an item with no comparison to make (path_case other than 2) is answered at
// the transfer edge, where its result is loaded into the output register
// a compared item walks six sequencer steps (window products, backlog, select,
// completion-time products, beta weighting, decide); no new item is taken
// until the decide step is done and the sequencer is back in idle
// reset clears the sequencer, the output valid flag and the margin bit, and
// returns beta to 4
// a stalled result holds the output register; a new item is taken in the same
// cycle that the waiting result transfers
//
module ecf_subflow_send_or_wait_unit
    import ecf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    // result channel
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cmd_t       cmd;
    status_t    status;
    logic [7:0] beta_reg;
    logic [7:0] beta_next;
    logic       reg_sel;

    // register index from the word address; only beta exists
    assign reg_sel = paddr[2];

    // beta register write on the access phase
    always_comb
    begin
        beta_next = beta_reg;
        if (psel && penable && pwrite && (reg_sel == REG_BETA))
        begin
            beta_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg <= BETA_RESET;
        end
        else
        begin
            beta_reg <= beta_next;
        end
    end

    // read back, unmapped words read as zero
    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_BETA)
        begin
            prdata = {24'b0, beta_reg};
        end
    end

    // no wait states
    assign pready = 1'b1;

    // sequencer
    ecf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // arithmetic, margin bit and output register
    ecf_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .beta         (beta_reg),
        .result_ready (result_ready),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== hdl/ecf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecf_ctrl
// Sequencer that steps one item through the datapath stages.
// ----------------------------------------------------------------------------
module ecf_ctrl
    import ecf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  logic    result_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_ready = (state_reg == ST_IDLE) && (!status.out_busy || result_ready);
    assign accept     = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.need_calc)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_BACK;
            ST_BACK: state_next = ST_SEL;
            ST_SEL:  state_next = ST_PROD;
            ST_PROD: state_next = ST_WGT;
            ST_WGT:  state_next = ST_DEC;
            ST_DEC:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        cmd.load   = accept;
        cmd.direct = accept && !status.need_calc;
        unique case (state_reg)
            ST_IDLE: ;
            ST_MUL:  cmd.mul_en  = 1'b1;
            ST_BACK: cmd.back_en = 1'b1;
            ST_SEL:  cmd.sel_en  = 1'b1;
            ST_PROD: cmd.prod_en = 1'b1;
            ST_WGT:  cmd.wgt_en  = 1'b1;
            ST_DEC:  cmd.dec_en  = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== hdl/ecf_dpath.sv =====
// ----------------------------------------------------------------------------
// ecf_dpath
// Backlog, completion-time products and the send/wait decision.
// ----------------------------------------------------------------------------
module ecf_dpath
    import ecf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  item_t      item,
    input  logic [7:0] beta,
    input  logic       result_ready,
    output status_t    status,
    output logic       result_valid,
    output result_t    result
);

    item_t        in_reg;
    logic [28:0]  srtt_f;
    logic [28:0]  srtt_s;
    logic [30:0]  var_f;
    logic [30:0]  var_s;
    logic [30:0]  delta;

    logic [31:0]  win_f_reg, win_f_next;
    logic [31:0]  win_s_reg, win_s_next;
    logic [47:0]  over_reg, over_next;
    logic [31:0]  fsum_reg, fsum_next;
    logic [31:0]  ssum_reg, ssum_next;
    logic [48:0]  minus;
    logic [31:0]  backlog_reg, backlog_next;
    logic [31:0]  x_f;
    logic [32:0]  xfs_reg, xfs_next;
    logic [31:0]  xs_reg, xs_next;
    logic [61:0]  lhs_reg, lhs_next;
    logic [63:0]  rhs_reg, rhs_next;
    logic [60:0]  lhs_s_reg, lhs_s_next;
    logic [63:0]  rhs_s_reg, rhs_s_next;
    logic [69:0]  wl_reg, wl_next;
    logic [72:0]  wr_reg, wr_next;
    logic         cmp_s_reg, cmp_s_next;
    logic         margin_reg, margin_next;
    logic         out_valid_reg, out_valid_next;
    result_t      out_reg, out_next;

    assign srtt_f = in_reg.fast_rtt[31:3];
    assign srtt_s = in_reg.slow_rtt[31:3];
    assign var_f  = in_reg.fast_rtt_var[31:1];
    assign var_s  = in_reg.slow_rtt_var[31:1];
    assign delta  = (var_f > var_s) ? var_f : var_s;

    // window sizes, excess in-flight bytes, rtt sums
    always_comb
    begin
        win_f_next = {16'b0, in_reg.fast_window} * {16'b0, in_reg.seg_size};
        win_s_next = {16'b0, in_reg.slow_window} * {16'b0, in_reg.seg_size};
        if (in_reg.meta_packets_out > in_reg.sub_inflight_pkts)
        begin
            over_next = {16'b0, in_reg.meta_packets_out - in_reg.sub_inflight_pkts}
                        * {32'b0, in_reg.seg_size};
        end
        else
        begin
            over_next = '0;
        end
        fsum_next = {3'b0, srtt_s} + {1'b0, delta};
        ssum_next = {2'b0, srtt_f, 1'b0} + {1'b0, delta};
    end

    // unsent backlog
    always_comb
    begin
        minus = {17'b0, in_reg.sub_queued_bytes} + {1'b0, over_reg};
        if ({17'b0, in_reg.meta_queued_bytes} > minus)
        begin
            backlog_next = in_reg.meta_queued_bytes - minus[31:0];
        end
        else
        begin
            backlog_next = '0;
        end
    end

    // amounts to send on each path
    always_comb
    begin
        x_f      = (backlog_reg > win_f_reg) ? backlog_reg : win_f_reg;
        xfs_next = {1'b0, x_f} + {1'b0, win_f_reg};
        xs_next  = (backlog_reg > win_s_reg) ? backlog_reg : win_s_reg;
    end

    // completion-time products
    always_comb
    begin
        lhs_next   = {33'b0, srtt_f} * {29'b0, xfs_reg};
        rhs_next   = {32'b0, win_f_reg} * {32'b0, fsum_reg};
        lhs_s_next = {32'b0, srtt_s} * {29'b0, xs_reg};
        rhs_s_next = {32'b0, win_s_reg} * {32'b0, ssum_reg};
    end

    // beta weighting with hysteresis margin
    always_comb
    begin
        wl_next    = {8'b0, lhs_reg} * {62'b0, beta};
        wr_next    = {9'b0, rhs_reg} * {64'b0, {1'b0, beta} + {8'b0, margin_reg}};
        cmp_s_next = ({3'b0, lhs_s_reg} >= rhs_s_reg);
    end

    // decision and output register
    always_comb
    begin
        margin_next    = margin_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        if (cmd.direct)
        begin
            out_valid_next        = 1'b1;
            out_next.decision     = (item.path_case == PATH_SAME) ? DEC_SEND_FAST : DEC_NONE;
            out_next.margin_after = margin_reg;
        end
        else if (cmd.dec_en)
        begin
            out_valid_next    = 1'b1;
            out_next.decision = DEC_SEND_SLOW;
            if ({3'b0, wl_reg} < wr_reg)
            begin
                if (cmp_s_reg)
                begin
                    margin_next       = 1'b1;
                    out_next.decision = DEC_WAIT;
                end
            end
            else
            begin
                margin_next = 1'b0;
            end
            out_next.margin_after = margin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= item;
        end
        if (cmd.mul_en)
        begin
            win_f_reg <= win_f_next;
            win_s_reg <= win_s_next;
            over_reg  <= over_next;
            fsum_reg  <= fsum_next;
            ssum_reg  <= ssum_next;
        end
        if (cmd.back_en)
        begin
            backlog_reg <= backlog_next;
        end
        if (cmd.sel_en)
        begin
            xfs_reg <= xfs_next;
            xs_reg  <= xs_next;
        end
        if (cmd.prod_en)
        begin
            lhs_reg   <= lhs_next;
            rhs_reg   <= rhs_next;
            lhs_s_reg <= lhs_s_next;
            rhs_s_reg <= rhs_s_next;
        end
        if (cmd.wgt_en)
        begin
            wl_reg    <= wl_next;
            wr_reg    <= wr_next;
            cmp_s_reg <= cmp_s_next;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            margin_reg    <= margin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_busy  = out_valid_reg;
    assign status.need_calc = (item.path_case == PATH_DIFF);
    assign result_valid     = out_valid_reg;
    assign result           = out_reg;

endmodule

// ===== hdl/ecf_checker.sv =====
// ----------------------------------------------------------------------------
// ecf_checker
// Port-level checks for the send/wait unit, bound to the top level.
// ----------------------------------------------------------------------------
module ecf_checker
    import ecf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input item_t              item,
    input logic               result_valid,
    input logic               result_ready,
    input result_t            result,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    // a waiting result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a wait decision always leaves the margin set
    a_wait_margin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.decision == DEC_WAIT) |-> result.margin_after)
        else $error("wait without margin");

    // an item transfer never overwrites a pending result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |-> !result_valid || result_ready)
        else $error("item taken while result pending");

    // config port has no wait states
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind ecf_subflow_send_or_wait_unit ecf_checker u_checker (.*);

// ===== test/ecf_subflow_send_or_wait_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecf_subflow_send_or_wait_unit_test
// Self-checking bench for the earliest-completion-first send/wait unit. An
// exact-width predictor of the decision and the margin bit follows every item
// transfer. Each result transfer is checked against the oldest prediction.
// Stimulus is a directed set, then random phases over several beta settings
// with random idling on both channels, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module ecf_subflow_send_or_wait_unit_test
    import ecf_pkg::*;
();

    // beta register address on the configuration port
    localparam int BETA_ADDR = 4 * REG_BETA;

    // ------------------------------------------------------------------------
    // decision predictor and store of pending decisions
    // ------------------------------------------------------------------------
    class ecf_decision_board;
        result_t    pending_decisions[$];
        logic [7:0] beta_recip;
        logic       margin;
        int         mismatches;

        function new();
            beta_recip = BETA_RESET;
            margin     = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_decisions.size();
        endfunction

        // work out the decision for one item transfer, all products at full width
        function void note_item(item_t it);
            logic [127:0] mss, meta_q, sub_q, meta_p, sub_p;
            logic [127:0] srtt_f, srtt_s, var_f, var_s, win_f, win_s;
            logic [127:0] delta, minus, backlog, x_f, x_s;
            logic [127:0] lhs, rhs, lhs_s, rhs_s, beta_w, weight_w;
            decision_t    dec;
            result_t      want;
            mss    = 128'(it.seg_size);
            meta_q = 128'(it.meta_queued_bytes);
            sub_q  = 128'(it.sub_queued_bytes);
            meta_p = 128'(it.meta_packets_out);
            sub_p  = 128'(it.sub_inflight_pkts);
            srtt_f = 128'(it.fast_rtt) >> 3;
            srtt_s = 128'(it.slow_rtt) >> 3;
            var_f  = 128'(it.fast_rtt_var) >> 1;
            var_s  = 128'(it.slow_rtt_var) >> 1;
            win_f  = 128'(it.fast_window) * mss;
            win_s  = 128'(it.slow_window) * mss;
            case (it.path_case)
                PATH_SAME:
                begin
                    dec = DEC_SEND_FAST;
                end
                PATH_DIFF:
                begin
                    delta = (var_f > var_s) ? var_f : var_s;
                    minus = sub_q;
                    if (meta_p > sub_p)
                    begin
                        minus = minus + (meta_p - sub_p) * mss;
                    end
                    backlog  = (meta_q > minus) ? meta_q - minus : 128'd0;
                    x_f      = (backlog > win_f) ? backlog : win_f;
                    lhs      = srtt_f * (x_f + win_f);
                    rhs      = win_f * (srtt_s + delta);
                    beta_w   = 128'(beta_recip);
                    weight_w = beta_w + 128'(margin);
                    if (lhs * beta_w < rhs * weight_w)
                    begin
                        x_s   = (backlog > win_s) ? backlog : win_s;
                        lhs_s = srtt_s * x_s;
                        rhs_s = win_s * ((srtt_f << 1) + delta);
                        if (lhs_s >= rhs_s)
                        begin
                            margin = 1'b1;
                            dec    = DEC_WAIT;
                        end
                        else
                        begin
                            // chosen path kept, margin left alone
                            dec = DEC_SEND_SLOW;
                        end
                    end
                    else
                    begin
                        margin = 1'b0;
                        dec    = DEC_SEND_SLOW;
                    end
                end
                default:
                begin
                    // no path, and the unused code handled the same way
                    dec = DEC_NONE;
                end
            endcase
            want.decision     = dec;
            want.margin_after = margin;
            pending_decisions.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_decision(result_t got);
            result_t want;
            if (pending_decisions.size() == 0)
            begin
                report_mismatch("result transfer with no item outstanding");
                return;
            end
            want = pending_decisions.pop_front();
            if (got.decision !== want.decision)
            begin
                report_mismatch($sformatf("decision %0d, expected %0d",
                                          got.decision, want.decision));
            end
            if (got.margin_after !== want.margin_after)
            begin
                report_mismatch($sformatf("margin_after %0b, expected %0b",
                                          got.margin_after, want.margin_after));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    item_t              item;
    logic               result_valid;
    logic               result_ready;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    ecf_decision_board board = new();

    // idle odds in percent, and a long output stall counted down
    int send_idle = 0;
    int recv_idle = 0;
    int hold_left = 0;

    ecf_subflow_send_or_wait_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous cap on the whole run
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // transfer monitor: predict on item transfers, check on result transfers
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                board.note_item(item);
            end
            if (result_valid && result_ready)
            begin
                board.check_decision(result);
            end
        end
    end

    // result side: random stalls, or a forced hold-off while hold_left runs
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers, all called right after a rising edge
    // ------------------------------------------------------------------------

    // offer one item, with random gaps before it, and hold it until transfer
    task push_item(item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
    endtask

    task wait_drained();
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // setup cycle then access cycle; the register takes the data at the end of
    // the access cycle since pready never drops
    task apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // beta changes only with the unit idle: every decision in and a short pause
    task set_beta(logic [7:0] value);
        wait_drained();
        repeat (10) @(posedge clk);
        apb_write(BETA_ADDR[PADDR_W-1:0], {24'd0, value});
        board.beta_recip = value;
    endtask

    function automatic item_t make_item(logic [1:0] pc, logic [15:0] mss,
                                        logic [31:0] mq, logic [31:0] sq,
                                        logic [31:0] mp, logic [31:0] sp,
                                        logic [15:0] wf, logic [31:0] rf,
                                        logic [31:0] vf, logic [15:0] ws,
                                        logic [31:0] rs, logic [31:0] vs);
        item_t it;
        it.path_case         = pc;
        it.seg_size          = mss;
        it.meta_queued_bytes = mq;
        it.sub_queued_bytes  = sq;
        it.meta_packets_out  = mp;
        it.sub_inflight_pkts = sp;
        it.fast_window       = wf;
        it.fast_rtt          = rf;
        it.fast_rtt_var      = vf;
        it.slow_window       = ws;
        it.slow_rtt          = rs;
        it.slow_rtt_var      = vs;
        return it;
    endfunction

    // mostly plausible two-path items with random content, some noise
    function automatic item_t rand_item();
        item_t           it;
        int unsigned     pick;
        int unsigned     base;
        longint unsigned queued;
        pick = $urandom_range(99);
        it   = make_item(2'($urandom), 16'($urandom), $urandom, $urandom, $urandom,
                         $urandom, 16'($urandom), $urandom, $urandom, 16'($urandom),
                         $urandom, $urandom);
        if (pick < 10)
        begin
            // fully random, unused path code included
            return it;
        end
        if (pick < 20)
        begin
            case (pick % 3)
                0:       it.path_case = PATH_NONE;
                1:       it.path_case = PATH_SAME;
                default: it.path_case = PATH_UNUSED;
            endcase
            return it;
        end
        it.path_case = PATH_DIFF;
        base         = $urandom_range(50000, 200);
        if ($urandom_range(9) == 0)
        begin
            it.seg_size = 16'($urandom_range(65535, 1));
        end
        else
        begin
            it.seg_size = 16'($urandom_range(1460, 500));
        end
        it.fast_window  = 16'($urandom_range(64, 1));
        it.slow_window  = 16'($urandom_range(64, 1));
        it.fast_rtt     = 8 * base;
        it.fast_rtt_var = 2 * $urandom_range(base / 2, 0);
        it.slow_rtt     = 8 * (base * $urandom_range(5, 1) + $urandom_range(base, 0));
        it.slow_rtt_var = 2 * $urandom_range(base / 2, 0);
        it.meta_packets_out = $urandom_range(200, 0);
        if ($urandom_range(9) == 0)
        begin
            it.sub_inflight_pkts = $urandom_range(300, 0);
        end
        else
        begin
            it.sub_inflight_pkts = $urandom_range(it.meta_packets_out, 0);
        end
        it.sub_queued_bytes = $urandom_range(200000, 0);
        // meta queue sized around what is already spoken for
        queued = 64'(it.sub_queued_bytes);
        if (it.meta_packets_out > it.sub_inflight_pkts)
        begin
            queued += 64'(it.meta_packets_out - it.sub_inflight_pkts) * 64'(it.seg_size);
        end
        queued += 64'($urandom_range(3000000, 0));
        if ($urandom_range(3) == 0)
        begin
            queued = queued / 2;
        end
        it.meta_queued_bytes = (queued > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : queued[31:0];
        return it;
    endfunction

    // edges of the fields, every path code and the hysteresis corners
    task run_directed();
        // no path at all zeros, same path and unused code at all ones
        push_item(make_item(PATH_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_item(make_item(PATH_SAME, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        push_item(make_item(PATH_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        // compared items with all zero and all ones
        push_item(make_item(PATH_DIFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_item(make_item(PATH_DIFF, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        // slow chosen path, wait for the fastest, margin set
        push_item(make_item(PATH_DIFF, 1000, 0, 0, 0, 0, 10, 8000, 0, 10, 40000, 0));
        // margin must survive items with nothing to compare
        push_item(make_item(PATH_NONE, 1000, 5, 5, 5, 5, 10, 8000, 0, 10, 40000, 0));
        push_item(make_item(PATH_SAME, 1000, 5, 5, 5, 5, 10, 8000, 0, 10, 40000, 0));
        push_item(make_item(PATH_UNUSED, 1000, 5, 5, 5, 5, 10, 8000, 0, 10, 40000, 0));
        // weighted test passes but chosen path not too slow: send, margin kept
        push_item(make_item(PATH_DIFF, 1000, 0, 0, 0, 0, 10, 8000, 3000, 10, 24000, 0));
        // exact tie that only the margin bit tips toward waiting
        push_item(make_item(PATH_DIFF, 1000, 0, 0, 0, 0, 10, 8000, 0, 10, 16000, 0));
        push_item(make_item(PATH_DIFF, 1000, 0, 0, 0, 0, 10, 8000, 0, 10, 16000, 0));
        // equal paths: test fails, margin cleared
        push_item(make_item(PATH_DIFF, 1000, 0, 0, 0, 0, 10, 8000, 0, 10, 8000, 0));
        // same tie again with margin clear: send slow
        push_item(make_item(PATH_DIFF, 1000, 0, 0, 0, 0, 10, 8000, 0, 10, 16000, 0));
        // big backlog, then more packets on subflows than at connection level
        push_item(make_item(PATH_DIFF, 1460, '1, 0, 100, 50, 20, 8000, 400, 20, 48000, 800));
        push_item(make_item(PATH_DIFF, 1460, 900000, 1000, 10, 90, 20, 8000, 400, 20,
                            48000, 800));
        // zero windows, zero segment size
        push_item(make_item(PATH_DIFF, 1460, 500000, 0, 30, 10, 0, 8000, 200, 0, 48000, 200));
        push_item(make_item(PATH_DIFF, 0, 500000, 0, 30, 10, 20, 8000, 200, 20, 48000, 200));
        // widest products: max rtts, windows, segment size
        push_item(make_item(PATH_DIFF, '1, '1, 0, 0, 0, '1, 32'hFFFF_FFF8, '1, '1, '1, '1));
        push_item(make_item(PATH_DIFF, '1, '1, 0, 0, 0, '1, '1, 0, '1, '1, '1));
        item_valid <= 1'b0;
    endtask

    // one stretch of random items; with stress set, a long result hold-off
    // a third of the way in and a full drain two thirds of the way in
    task run_phase(int count, int s_idle, int r_idle, bit stress);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int n = 0; n < count; n++)
        begin
            if (stress && n == count / 3)
            begin
                hold_left = 150;
            end
            if (stress && n == 2 * count / 3)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                wait_drained();
            end
            push_item(rand_item());
        end
        item_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of beta first
        run_directed();

        // sender rarely idle, receiver mostly stalled
        set_beta(8'd1);
        run_phase(350, 6, 75, 1'b0);
        set_beta(8'd255);
        run_directed();
        run_phase(250, 6, 75, 1'b0);

        // sender mostly idle, receiver rarely stalled
        set_beta(8'd0);
        run_phase(150, 75, 6, 1'b0);
        set_beta(8'($urandom_range(254, 2)));
        run_phase(350, 75, 6, 1'b0);

        // no idling on either side, then the back-pressure stretch
        set_beta(8'd2);
        run_phase(300, 0, 0, 1'b0);
        set_beta(BETA_RESET);
        run_phase(350, 0, 0, 1'b1);

        wait_drained();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
